### rtl/ltpsp_pkg.sv
// ----------------------------------------------------------------------------
// ltpsp_pkg
// Shared types and codes of the segment header parser: parse phases, field
// identifiers, status codes and the result beat structure.
// ----------------------------------------------------------------------------
package ltpsp_pkg;

    // parse phases
    localparam logic [4:0] PH_CTRL    = 5'd0;
    localparam logic [4:0] PH_ENGINE  = 5'd1;
    localparam logic [4:0] PH_SESSION = 5'd2;
    localparam logic [4:0] PH_HCOUNT  = 5'd3;
    localparam logic [4:0] PH_TCOUNT  = 5'd4;
    localparam logic [4:0] PH_HTAG    = 5'd5;
    localparam logic [4:0] PH_HLEN    = 5'd6;
    localparam logic [4:0] PH_HVAL    = 5'd7;
    localparam logic [4:0] PH_CSID    = 5'd8;
    localparam logic [4:0] PH_DOFF    = 5'd9;
    localparam logic [4:0] PH_DLEN    = 5'd10;
    localparam logic [4:0] PH_DCP     = 5'd11;
    localparam logic [4:0] PH_DRS     = 5'd12;
    localparam logic [4:0] PH_PAY     = 5'd13;
    localparam logic [4:0] PH_RRS     = 5'd14;
    localparam logic [4:0] PH_RCP     = 5'd15;
    localparam logic [4:0] PH_UB      = 5'd16;
    localparam logic [4:0] PH_LB      = 5'd17;
    localparam logic [4:0] PH_CCOUNT  = 5'd18;
    localparam logic [4:0] PH_CLAIM   = 5'd19;
    localparam logic [4:0] PH_RA      = 5'd20;
    localparam logic [4:0] PH_REASON  = 5'd21;
    localparam logic [4:0] PH_TTAG    = 5'd22;
    localparam logic [4:0] PH_TLEN    = 5'd23;
    localparam logic [4:0] PH_TVAL    = 5'd24;
    localparam logic [4:0] PH_DONE    = 5'd25;
    localparam logic [4:0] PH_SKIP    = 5'd26;

    // field identifiers
    localparam logic [4:0] FID_CTRL    = 5'd0;
    localparam logic [4:0] FID_ENGINE  = 5'd1;
    localparam logic [4:0] FID_SESSION = 5'd2;
    localparam logic [4:0] FID_HCOUNT  = 5'd3;
    localparam logic [4:0] FID_TCOUNT  = 5'd4;
    localparam logic [4:0] FID_HTAG    = 5'd5;
    localparam logic [4:0] FID_HLEN    = 5'd6;
    localparam logic [4:0] FID_HVAL    = 5'd7;
    localparam logic [4:0] FID_CSID    = 5'd8;
    localparam logic [4:0] FID_DOFF    = 5'd9;
    localparam logic [4:0] FID_DLEN    = 5'd10;
    localparam logic [4:0] FID_CPSER   = 5'd11;
    localparam logic [4:0] FID_RPSER   = 5'd12;
    localparam logic [4:0] FID_PAY     = 5'd13;
    localparam logic [4:0] FID_UB      = 5'd14;
    localparam logic [4:0] FID_LB      = 5'd15;
    localparam logic [4:0] FID_CCOUNT  = 5'd16;
    localparam logic [4:0] FID_COFF    = 5'd17;
    localparam logic [4:0] FID_CLEN    = 5'd18;
    localparam logic [4:0] FID_REASON  = 5'd19;
    localparam logic [4:0] FID_END     = 5'd20;
    localparam logic [4:0] FID_TTAG    = 5'd21;
    localparam logic [4:0] FID_TLEN    = 5'd22;
    localparam logic [4:0] FID_TVAL    = 5'd23;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_VERSION = 3'd1;
    localparam logic [2:0] ST_TYPE    = 3'd2;
    localparam logic [2:0] ST_SDNV    = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;

    // bit set per valid segment type
    localparam logic [15:0] TYPE_VALID_MASK = 16'hF39F;
    localparam logic [3:0]  TYPE_NIBBLE     = 4'hF;

    typedef struct packed {
        logic [4:0]  field_id;
        logic [63:0] field_value;
        logic [2:0]  parse_status;
        logic        segment_end;
    } t_res;

endpackage

### rtl/ltpsp_core.sv
// ----------------------------------------------------------------------------
// ltpsp_core
// Parse state and per-byte decode; gives up to two result beats per byte.
// ----------------------------------------------------------------------------
module ltpsp_core #(
    parameter int SDNV_MAX_BYTES = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_seg_byte,
    input  logic              i_last_byte,
    output ltpsp_pkg::t_res   o_res0,
    output ltpsp_pkg::t_res   o_res1,
    output logic [1:0]        o_num
);
    import ltpsp_pkg::*;

    localparam int CW = $clog2(SDNV_MAX_BYTES + 1);

    logic [4:0]  r_phase, n_phase;
    logic [3:0]  r_type, n_type;
    logic [63:0] r_acc, n_acc;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]  r_ext, n_ext;
    logic [7:0]  r_tot, n_tot;
    logic [63:0] r_left, n_left;
    logic [63:0] r_claims, n_claims;
    logic        r_half, n_half;
    logic [2:0]  r_err, n_err;

    // content phase from segment type; trailer entry when no content
    function automatic logic [4:0] f_content(input logic [3:0] t, input logic [7:0] tot);
        logic [4:0] p;
        if (t <= 4'd7)                      p = PH_CSID;
        else if (t == 4'd8)                 p = PH_RRS;
        else if (t == 4'd9)                 p = PH_RA;
        else if (t == 4'd12 || t == 4'd14)  p = PH_REASON;
        else                                p = (tot != 8'd0) ? PH_TTAG : PH_DONE;
        return p;
    endfunction

    function automatic logic [4:0] f_trailer(input logic [7:0] tot);
        return (tot != 8'd0) ? PH_TTAG : PH_DONE;
    endfunction

    logic        e_vld;
    logic [4:0]  e_id;
    logic [63:0] e_val;
    logic [2:0]  end_st;

    // per-byte decode
    always_comb begin
        logic [63:0] sd_val;
        logic        sd_bad;
        logic [7:0]  ext_m1;
        logic [63:0] left_m1;
        logic [63:0] claims_m1;
        n_phase  = r_phase;
        n_type   = r_type;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_ext    = r_ext;
        n_tot    = r_tot;
        n_left   = r_left;
        n_claims = r_claims;
        n_half   = r_half;
        n_err    = r_err;
        e_vld    = 1'b0;
        e_id     = FID_CTRL;
        e_val    = 64'd0;
        sd_val    = {r_acc[56:0], i_seg_byte[6:0]};
        sd_bad    = (r_cnt >= CW'(SDNV_MAX_BYTES)) || (r_acc[63:57] != 7'd0);
        ext_m1    = r_ext - 8'd1;
        left_m1   = r_left - 64'd1;
        claims_m1 = r_claims - 64'd1;
        unique case (r_phase)
            PH_CTRL: begin
                if (i_seg_byte[7:4] != 4'd0) begin
                    n_err = ST_VERSION; n_phase = PH_SKIP;
                end else if (!TYPE_VALID_MASK[i_seg_byte[3:0]]) begin
                    n_err = ST_TYPE; n_phase = PH_SKIP;
                end else begin
                    n_type = i_seg_byte[3:0] & TYPE_NIBBLE;
                    e_vld = 1'b1; e_id = FID_CTRL; e_val = {60'd0, i_seg_byte[3:0]};
                    n_phase = PH_ENGINE;
                end
            end
            PH_HCOUNT: begin
                e_vld = 1'b1; e_id = FID_HCOUNT; e_val = {56'd0, i_seg_byte};
                n_ext = i_seg_byte; n_phase = PH_TCOUNT;
            end
            PH_TCOUNT: begin
                e_vld = 1'b1; e_id = FID_TCOUNT; e_val = {56'd0, i_seg_byte};
                n_tot = i_seg_byte;
                if (r_ext != 8'd0) n_phase = PH_HTAG;
                else begin
                    n_ext = i_seg_byte; n_phase = f_content(r_type, i_seg_byte);
                end
            end
            PH_HTAG: begin
                e_vld = 1'b1; e_id = FID_HTAG; e_val = {56'd0, i_seg_byte};
                n_phase = PH_HLEN;
            end
            PH_HVAL: begin
                e_vld = 1'b1; e_id = FID_HVAL; e_val = {56'd0, i_seg_byte};
                n_left = left_m1;
                if (left_m1 == 64'd0) begin
                    n_ext = ext_m1;
                    if (ext_m1 != 8'd0) n_phase = PH_HTAG;
                    else begin
                        n_ext = r_tot; n_phase = f_content(r_type, r_tot);
                    end
                end
            end
            PH_PAY: begin
                e_vld = 1'b1; e_id = FID_PAY; e_val = {56'd0, i_seg_byte};
                n_left = left_m1;
                if (left_m1 == 64'd0) begin
                    n_ext = r_tot; n_phase = f_trailer(r_tot);
                end
            end
            PH_REASON: begin
                e_vld = 1'b1; e_id = FID_REASON; e_val = {56'd0, i_seg_byte};
                n_ext = r_tot; n_phase = f_trailer(r_tot);
            end
            PH_TTAG: begin
                e_vld = 1'b1; e_id = FID_TTAG; e_val = {56'd0, i_seg_byte};
                n_phase = PH_TLEN;
            end
            PH_TVAL: begin
                e_vld = 1'b1; e_id = FID_TVAL; e_val = {56'd0, i_seg_byte};
                n_left = left_m1;
                if (left_m1 == 64'd0) begin
                    n_ext = ext_m1;
                    n_phase = (ext_m1 != 8'd0) ? PH_TTAG : PH_DONE;
                end
            end
            PH_DONE, PH_SKIP: begin
            end
            default: begin
                if (r_phase > PH_SKIP) begin
                    n_err = ST_TRUNC; n_phase = PH_SKIP;
                end else if (sd_bad) begin
                    n_err = ST_SDNV; n_phase = PH_SKIP;
                end else if (i_seg_byte[7]) begin
                    n_cnt = r_cnt + CW'(1);
                    n_acc = sd_val;
                end else begin
                    n_cnt = '0;
                    n_acc = 64'd0;
                    e_vld = 1'b1;
                    e_val = sd_val;
                    // completed sdnv field
                    priority case (r_phase)
                        PH_ENGINE:  begin e_id = FID_ENGINE;  n_phase = PH_SESSION; end
                        PH_SESSION: begin e_id = FID_SESSION; n_phase = PH_HCOUNT;  end
                        PH_HLEN: begin
                            e_id = FID_HLEN; n_left = sd_val;
                            if (sd_val != 64'd0) n_phase = PH_HVAL;
                            else begin
                                n_ext = ext_m1;
                                if (ext_m1 != 8'd0) n_phase = PH_HTAG;
                                else begin
                                    n_ext = r_tot; n_phase = f_content(r_type, r_tot);
                                end
                            end
                        end
                        PH_CSID: begin e_id = FID_CSID; n_phase = PH_DOFF; end
                        PH_DOFF: begin e_id = FID_DOFF; n_phase = PH_DLEN; end
                        PH_DLEN: begin
                            e_id = FID_DLEN; n_left = sd_val;
                            if (r_type >= 4'd1 && r_type <= 4'd3) n_phase = PH_DCP;
                            else if (sd_val == 64'd0) begin
                                n_ext = r_tot; n_phase = f_trailer(r_tot);
                            end else n_phase = PH_PAY;
                        end
                        PH_DCP: begin e_id = FID_CPSER; n_phase = PH_DRS; end
                        PH_DRS: begin
                            e_id = FID_RPSER;
                            if (r_left == 64'd0) begin
                                n_ext = r_tot; n_phase = f_trailer(r_tot);
                            end else n_phase = PH_PAY;
                        end
                        PH_RRS: begin e_id = FID_RPSER; n_phase = PH_RCP; end
                        PH_RCP: begin e_id = FID_CPSER; n_phase = PH_UB;  end
                        PH_UB:  begin e_id = FID_UB;    n_phase = PH_LB;  end
                        PH_LB:  begin e_id = FID_LB;    n_phase = PH_CCOUNT; end
                        PH_CCOUNT: begin
                            e_id = FID_CCOUNT; n_claims = sd_val; n_half = 1'b0;
                            if (sd_val == 64'd0) begin
                                n_ext = r_tot; n_phase = f_trailer(r_tot);
                            end else n_phase = PH_CLAIM;
                        end
                        PH_CLAIM: begin
                            if (!r_half) begin
                                e_id = FID_COFF; n_half = 1'b1;
                            end else begin
                                e_id = FID_CLEN; n_half = 1'b0; n_claims = claims_m1;
                                if (claims_m1 == 64'd0) begin
                                    n_ext = r_tot; n_phase = f_trailer(r_tot);
                                end
                            end
                        end
                        PH_RA: begin
                            e_id = FID_RPSER; n_ext = r_tot; n_phase = f_trailer(r_tot);
                        end
                        PH_TLEN: begin
                            e_id = FID_TLEN; n_left = sd_val;
                            if (sd_val != 64'd0) n_phase = PH_TVAL;
                            else begin
                                n_ext = ext_m1;
                                n_phase = (ext_m1 != 8'd0) ? PH_TTAG : PH_DONE;
                            end
                        end
                        default: e_vld = 1'b0;
                    endcase
                end
            end
        endcase
        // truncation check at the end of a segment
        end_st = (n_err == ST_OK && n_phase != PH_DONE) ? ST_TRUNC : n_err;
    end

    // result beats, compacted
    always_comb begin
        t_res f, e;
        f = '{field_id: e_id, field_value: e_val, parse_status: ST_OK, segment_end: 1'b0};
        e = '{field_id: FID_END, field_value: 64'd0, parse_status: end_st, segment_end: 1'b1};
        o_res1 = e;
        if (e_vld) begin
            o_res0 = f;
            o_num  = i_last_byte ? 2'd2 : 2'd1;
        end else begin
            o_res0 = e;
            o_num  = i_last_byte ? 2'd1 : 2'd0;
        end
    end

    // parse state, cleared at reset and after each end beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last_byte)) begin
            r_phase  <= PH_CTRL;
            r_type   <= 4'd0;
            r_acc    <= 64'd0;
            r_cnt    <= '0;
            r_ext    <= 8'd0;
            r_tot    <= 8'd0;
            r_left   <= 64'd0;
            r_claims <= 64'd0;
            r_half   <= 1'b0;
            r_err    <= ST_OK;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_ext    <= n_ext;
            r_tot    <= n_tot;
            r_left   <= n_left;
            r_claims <= n_claims;
            r_half   <= n_half;
            r_err    <= n_err;
        end
    end

endmodule

### rtl/ltp_segment_parser_unit.sv
// ----------------------------------------------------------------------------
// ltp_segment_parser_unit
// Segment header parser: one byte per beat in, decoded field beats out.
// A field beat is registered and shows in the cycle after its byte is taken.
// Throughput: one byte per cycle while the output is not stalled; a last byte
// that also closes a field gives two beats, and the two-entry result queue holds input.
// Reset: synchronous active low; parse state returns to the control phase.
// ----------------------------------------------------------------------------
module ltp_segment_parser_unit #(
    parameter int SDNV_MAX_BYTES = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_seg_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_field_id,
    output logic [63:0] o_field_value,
    output logic [2:0]  o_parse_status,
    output logic        o_segment_end
);
    import ltpsp_pkg::*;

    logic       take;
    logic       pop;
    t_res       res0, res1;
    logic [1:0] num;
    t_res       r_q0, r_q1;
    logic [1:0] r_cnt;

    // room when queue drains to empty this cycle
    assign o_stall = !((r_cnt == 2'd0) || (r_cnt == 2'd1 && !i_stall));
    assign take    = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && !i_stall;

    ltpsp_core #(
        .SDNV_MAX_BYTES(SDNV_MAX_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_seg_byte  (i_seg_byte),
        .i_last_byte (i_last_byte),
        .o_res0      (res0),
        .o_res1      (res1),
        .o_num       (num)
    );

    // result queue count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (take) begin
            r_cnt <= num;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // result queue payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_q0 <= res0;
            r_q1 <= res1;
        end else if (pop) begin
            r_q0 <= r_q1;
        end
    end

    assign o_field_id     = r_q0.field_id;
    assign o_field_value  = r_q0.field_value;
    assign o_parse_status = r_q0.parse_status;
    assign o_segment_end  = r_q0.segment_end;

    // checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("result queue overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> o_stall) else $error("input taken with full queue");
    a_end_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_segment_end) |-> (o_field_id == FID_END))
        else $error("end beat with wrong field id");
    a_status_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_segment_end) |-> (o_parse_status == ST_OK))
        else $error("status on a field beat");

endmodule

### bench/ltp_segment_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// ltp_segment_parser_unit_tb
// Self-checking bench for the segment header parser. A local predictor walks
// the same segment grammar byte by byte and queues the field beats it expects.
// A monitor compares every accepted output beat against the oldest one. Well
// formed segments of every type make up most of the stimulus, with broken
// control bytes, overlong SDNVs, truncation and trailing bytes mixed in.
// ----------------------------------------------------------------------------
module ltp_segment_parser_unit_tb;
    import ltpsp_pkg::*;

    typedef struct {
        logic [7:0] b;
        logic       last;
        bit         hold;
    } t_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_seg_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_stall;
    logic [4:0]  o_field_id;
    logic [63:0] o_field_value;
    logic [2:0]  o_parse_status;
    logic        o_segment_end;

    ltp_segment_parser_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_seg_byte(i_seg_byte), .i_last_byte(i_last_byte),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_field_id(o_field_id), .o_field_value(o_field_value),
        .o_parse_status(o_parse_status), .o_segment_end(o_segment_end)
    );

    localparam int SDNV_LIMIT = 10;
    localparam longint CYCLE_LIMIT = 400000;

    t_byte  byte_q[$];
    t_res   field_q[$];
    int     errors = 0;
    longint cycles = 0;
    bit     stim_done = 0;

    // predictor state
    logic [4:0]  ph;
    logic [3:0]  ptype;
    logic [63:0] acc;
    int          acc_n;
    logic [7:0]  ext_cnt, trl_total;
    logic [63:0] left_bytes, left_claims;
    bit          second_half;
    logic [2:0]  err;

    function automatic void parser_clear();
        ph = PH_CTRL; ptype = 0; acc = 0; acc_n = 0; ext_cnt = 0;
        trl_total = 0; left_bytes = 0; left_claims = 0; second_half = 0;
        err = ST_OK;
    endfunction

    function automatic void push_field(logic [4:0] id, logic [63:0] v);
        t_res r;
        r.field_id = id; r.field_value = v;
        r.parse_status = ST_OK; r.segment_end = 1'b0;
        field_q.insert(field_q.size(), r);
    endfunction

    // append one byte to the segment under construction
    function automatic void seg_add(logic [7:0] b);
        seg.insert(seg.size(), b);
    endfunction

    function automatic void go_trailer();
        ext_cnt = trl_total;
        ph = (ext_cnt != 0) ? PH_TTAG : PH_DONE;
    endfunction

    function automatic void go_content();
        if (ptype <= 7) ph = PH_CSID;
        else if (ptype == 8) ph = PH_RRS;
        else if (ptype == 9) ph = PH_RA;
        else if (ptype == 12 || ptype == 14) ph = PH_REASON;
        else go_trailer();
    endfunction

    function automatic void go_htag();
        if (ext_cnt != 0) ph = PH_HTAG;
        else go_content();
    endfunction

    function automatic void after_dlen();
        if (left_bytes == 0) go_trailer();
        else ph = PH_PAY;
    endfunction

    // a completed SDNV value in the current phase
    function automatic void sdnv_field(logic [63:0] v);
        case (ph)
            PH_ENGINE: begin push_field(FID_ENGINE, v); ph = PH_SESSION; end
            PH_SESSION: begin push_field(FID_SESSION, v); ph = PH_HCOUNT; end
            PH_HLEN: begin
                push_field(FID_HLEN, v);
                left_bytes = v;
                if (v == 0) begin ext_cnt--; go_htag(); end
                else ph = PH_HVAL;
            end
            PH_CSID: begin push_field(FID_CSID, v); ph = PH_DOFF; end
            PH_DOFF: begin push_field(FID_DOFF, v); ph = PH_DLEN; end
            PH_DLEN: begin
                push_field(FID_DLEN, v);
                left_bytes = v;
                if (ptype >= 1 && ptype <= 3) ph = PH_DCP;
                else after_dlen();
            end
            PH_DCP: begin push_field(FID_CPSER, v); ph = PH_DRS; end
            PH_DRS: begin push_field(FID_RPSER, v); after_dlen(); end
            PH_RRS: begin push_field(FID_RPSER, v); ph = PH_RCP; end
            PH_RCP: begin push_field(FID_CPSER, v); ph = PH_UB; end
            PH_UB: begin push_field(FID_UB, v); ph = PH_LB; end
            PH_LB: begin push_field(FID_LB, v); ph = PH_CCOUNT; end
            PH_CCOUNT: begin
                push_field(FID_CCOUNT, v);
                left_claims = v;
                second_half = 0;
                if (v == 0) go_trailer();
                else ph = PH_CLAIM;
            end
            PH_CLAIM: begin
                if (!second_half) begin
                    push_field(FID_COFF, v);
                    second_half = 1;
                end else begin
                    push_field(FID_CLEN, v);
                    second_half = 0;
                    left_claims--;
                    if (left_claims == 0) go_trailer();
                end
            end
            PH_RA: begin push_field(FID_RPSER, v); go_trailer(); end
            PH_TLEN: begin
                push_field(FID_TLEN, v);
                left_bytes = v;
                if (v == 0) begin
                    ext_cnt--;
                    ph = (ext_cnt != 0) ? PH_TTAG : PH_DONE;
                end else ph = PH_TVAL;
            end
            default: ;
        endcase
    endfunction

    // one accepted byte through the parser grammar
    function automatic void parse_byte(logic [7:0] b, logic last);
        t_res r;
        case (ph)
            PH_CTRL: begin
                if (b[7:4] != 0) begin err = ST_VERSION; ph = PH_SKIP; end
                else if (!TYPE_VALID_MASK[b[3:0]]) begin err = ST_TYPE; ph = PH_SKIP; end
                else begin
                    ptype = b[3:0];
                    push_field(FID_CTRL, {60'd0, b[3:0]});
                    ph = PH_ENGINE;
                end
            end
            PH_HCOUNT: begin
                push_field(FID_HCOUNT, {56'd0, b}); ext_cnt = b; ph = PH_TCOUNT;
            end
            PH_TCOUNT: begin
                push_field(FID_TCOUNT, {56'd0, b}); trl_total = b; go_htag();
            end
            PH_HTAG: begin push_field(FID_HTAG, {56'd0, b}); ph = PH_HLEN; end
            PH_HVAL: begin
                push_field(FID_HVAL, {56'd0, b});
                left_bytes--;
                if (left_bytes == 0) begin ext_cnt--; go_htag(); end
            end
            PH_PAY: begin
                push_field(FID_PAY, {56'd0, b});
                left_bytes--;
                if (left_bytes == 0) go_trailer();
            end
            PH_REASON: begin push_field(FID_REASON, {56'd0, b}); go_trailer(); end
            PH_TTAG: begin push_field(FID_TTAG, {56'd0, b}); ph = PH_TLEN; end
            PH_TVAL: begin
                push_field(FID_TVAL, {56'd0, b});
                left_bytes--;
                if (left_bytes == 0) begin
                    ext_cnt--;
                    ph = (ext_cnt != 0) ? PH_TTAG : PH_DONE;
                end
            end
            PH_DONE, PH_SKIP: ;
            default: begin
                if (acc_n >= SDNV_LIMIT || acc[63:57] != 0) begin
                    err = ST_SDNV; ph = PH_SKIP;
                end else begin
                    acc_n++;
                    acc = {acc[56:0], b[6:0]};
                    if (!b[7]) begin
                        logic [63:0] v;
                        v = acc; acc = 0; acc_n = 0;
                        sdnv_field(v);
                    end
                end
            end
        endcase
        if (last) begin
            if (err == ST_OK && ph != PH_DONE) err = ST_TRUNC;
            r.field_id = FID_END; r.field_value = 64'd0;
            r.parse_status = err; r.segment_end = 1'b1;
            field_q.insert(field_q.size(), r);
            parser_clear();
        end
    endfunction

    // ---------------- stimulus building ----------------
    logic [7:0] seg[$];

    function automatic void put_sdnv(logic [63:0] v);
        logic [7:0] t[$];
        t.push_front({1'b0, v[6:0]});
        v = v >> 7;
        while (v != 0) begin
            t.push_front({1'b1, v[6:0]});
            v = v >> 7;
        end
        foreach (t[i]) seg_add(t[i]);
    endfunction

    function automatic logic [63:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return {$urandom, $urandom};
            2: return 64'hFFFF_FFFF_FFFF_FFFF;
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    function automatic logic [63:0] rnd_len();
        return $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 6);
    endfunction

    function automatic void put_exts(int n);
        repeat (n) begin
            logic [63:0] l;
            seg_add(8'($urandom));
            l = rnd_len();
            put_sdnv(l);
            repeat (l) seg_add(8'($urandom));
        end
    endfunction

    // a well formed segment of the given type
    function automatic void build_segment(logic [3:0] t);
        int hx, tx;
        logic [63:0] n;
        hx = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
        tx = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
        seg.delete();
        seg_add({4'h0, t});
        put_sdnv(rnd_val());
        put_sdnv(rnd_val());
        seg_add(8'(hx));
        seg_add(8'(tx));
        put_exts(hx);
        if (t <= 7) begin
            put_sdnv(rnd_val());
            put_sdnv(rnd_val());
            n = $urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 12);
            put_sdnv(n);
            if (t >= 1 && t <= 3) begin put_sdnv(rnd_val()); put_sdnv(rnd_val()); end
            repeat (n) seg_add(8'($urandom));
        end else if (t == 8) begin
            // report serial, checkpoint serial, upper and lower bound
            repeat (4) put_sdnv(rnd_val());
            n = $urandom_range(0, 3);
            put_sdnv(n);
            repeat (2 * n) put_sdnv(rnd_val());
        end else if (t == 9) begin
            put_sdnv(rnd_val());
        end else if (t == 12 || t == 14) begin
            seg_add(8'($urandom));
        end
        put_exts(tx);
    endfunction

    function automatic void queue_seg(int last_at, bit hold_first);
        t_byte x;
        foreach (seg[i]) begin
            if (i > last_at) break;
            x.b = seg[i]; x.last = (i == last_at); x.hold = hold_first && i == 0;
            byte_q.insert(byte_q.size(), x);
        end
    endfunction

    function automatic logic [3:0] good_type();
        logic [3:0] t;
        do t = 4'($urandom); while (!TYPE_VALID_MASK[t]);
        return t;
    endfunction

    // random segment, mostly well formed
    function automatic void random_segment(bit hold);
        int k;
        k = $urandom_range(0, 19);
        build_segment(good_type());
        if (k < 13) begin
            queue_seg(seg.size() - 1, hold);
        end else if (k < 15) begin
            // truncated anywhere
            queue_seg($urandom_range(0, seg.size() - 2), hold);
        end else if (k == 15) begin
            // trailing bytes after completion
            repeat ($urandom_range(1, 3)) seg_add(8'($urandom));
            queue_seg(seg.size() - 1, hold);
        end else if (k == 16) begin
            seg[0] = {4'($urandom_range(1, 15)), seg[0][3:0]};
            queue_seg($urandom_range(0, seg.size() - 1), hold);
        end else if (k == 17) begin
            seg[0] = {4'h0, 4'(5 + 5 * $urandom_range(0, 1) + $urandom_range(0, 1))};
            queue_seg(seg.size() - 1, hold);
        end else begin
            // overlong sdnv in engine id
            seg.delete();
            seg_add({4'h0, good_type()});
            repeat ($urandom_range(10, 12)) seg_add(8'h80 | 8'($urandom));
            repeat ($urandom_range(0, 3)) seg_add(8'($urandom));
            queue_seg(seg.size() - 1, hold);
        end
    endfunction

    function automatic void directed_segments();
        // extremes: 64-bit engine id, 1-byte segment, each type, bad codes
        seg.delete();
        seg_add(8'h00);
        put_sdnv(64'hFFFF_FFFF_FFFF_FFFF);
        put_sdnv(0);
        seg_add(8'd1); seg_add(8'd1);
        seg_add(8'hFF); put_sdnv(1); seg_add(8'hFF);
        put_sdnv(0); put_sdnv(0); put_sdnv(1); seg_add(8'h00);
        seg_add(8'h7F); put_sdnv(0);
        queue_seg(seg.size() - 1, 0);
        seg.delete(); seg_add(8'hF0); queue_seg(0, 0);
        seg.delete(); seg_add(8'h05); queue_seg(0, 0);
        seg.delete(); seg_add(8'h0A); seg_add(8'h01); queue_seg(1, 0);
        seg.delete(); seg_add(8'h0D); queue_seg(0, 0);
        // value past 64 bits: eleven bytes with a nonzero top
        seg.delete(); seg_add(8'h00); seg_add(8'h82);
        repeat (9) seg_add(8'hFF);
        seg_add(8'h01);
        queue_seg(seg.size() - 1, 0);
        for (int t = 0; t < 16; t++)
            if (TYPE_VALID_MASK[t]) begin
                build_segment(4'(t));
                queue_seg(seg.size() - 1, 0);
            end
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int total;
        i_rst_n = 0;
        parser_clear();
        directed_segments();
        total = byte_q.size();
        while (total < 1100) begin
            int before_n;
            before_n = byte_q.size();
            random_segment(total > 550 && total < 620);
            total += byte_q.size() - before_n;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
    end

    // driver
    int  gap = 0;
    bit  holding = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0; i_seg_byte <= 0; i_last_byte <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                parse_byte(i_seg_byte, i_last_byte);
                gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 6) : 0;
            end
            if (!(i_valid && o_stall)) begin
                // wait here until every expected beat has come out
                if (byte_q.size() != 0 && byte_q[0].hold && !holding) begin
                    holding = 1;
                end
                if (holding && field_q.size() == 0) begin
                    holding = 0; byte_q[0].hold = 0;
                end
                if (gap > 0 || holding || byte_q.size() == 0) begin
                    if (gap > 0) gap--;
                    i_valid <= 0;
                    if (byte_q.size() == 0) stim_done = 1;
                end else begin
                    t_byte x;
                    x = byte_q.pop_front();
                    i_valid <= 1; i_seg_byte <= x.b; i_last_byte <= x.last;
                end
            end
        end
    end

    // output stall
    int rx_wait = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_stall <= 1;
        end else begin
            rx_wait = $urandom_range(0, 2) == 0 ? $urandom_range(0, 6) : 0;
            i_stall <= rx_wait > 0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (field_q.size() == 0) begin
                $display("%0t: unexpected beat id=%0d value=%h status=%0d end=%0b",
                         $time, o_field_id, o_field_value, o_parse_status, o_segment_end);
                errors++;
            end else begin
                e = field_q.pop_front();
                if (e.field_id !== o_field_id || e.field_value !== o_field_value
                        || e.parse_status !== o_parse_status
                        || e.segment_end !== o_segment_end) begin
                    $display("%0t: expected id=%0d value=%h status=%0d end=%0b",
                             $time, e.field_id, e.field_value, e.parse_status,
                             e.segment_end);
                    $display("%0t: actual   id=%0d value=%h status=%0d end=%0b",
                             $time, o_field_id, o_field_value, o_parse_status,
                             o_segment_end);
                    errors++;
                end
            end
        end
    end

    // end of run and watchdog
    int drain = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else if (stim_done && !i_valid && field_q.size() == 0) begin
            drain++;
            if (drain > 20) begin
                if (errors == 0) $display("SCOREBOARD CLEAN");
                else $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end else begin
            drain = 0;
        end
    end

endmodule

### files.f
rtl/ltpsp_pkg.sv
rtl/ltpsp_core.sv
rtl/ltp_segment_parser_unit.sv
bench/ltp_segment_parser_unit_tb.sv
